// File: rtl/vqcb_pkg.sv
// ----------------------------------------------------------------------------
// vqcb_pkg
// Shared constants and types of the vector codebook: table geometry, field
// widths, wildcard and no-match codes, and the structs between the scan
// control and the distance datapath.
// ----------------------------------------------------------------------------
package vqcb_pkg;

  localparam int unsigned ENTRIES        = 256;
  localparam int unsigned IDX_W          = $clog2(ENTRIES);
  localparam int unsigned USED_W         = $clog2(ENTRIES + 1);
  localparam int unsigned BYTES_PER_BEAT = 8;
  localparam int unsigned VECTOR_BYTES   = 64;
  localparam int unsigned BEATS          = VECTOR_BYTES / BYTES_PER_BEAT;
  localparam int unsigned BEAT_W         = $clog2(BEATS);
  localparam int unsigned CHUNK_W        = 64;
  localparam int unsigned ROW_W          = 8 * BYTES_PER_BEAT;
  localparam int unsigned TAG_W          = 8;
  localparam int unsigned DIST_W         = 14;
  localparam int unsigned ROWSUM_W       = 11;
  localparam int unsigned CNT_W          = 32;
  localparam int unsigned ADDR_W         = 3;
  localparam int unsigned DATA_W         = 32;

  localparam logic [TAG_W-1:0]  WILDCARD_TAG  = 8'hFF;
  localparam logic [DIST_W-1:0] NO_MATCH_DIST = 14'd16321;

  // Register index decoded from paddr[2]
  localparam logic REG_THRESHOLD = 1'b0;

  typedef struct packed {
    logic             vld;
    logic             last;
    logic [IDX_W-1:0] idx;
  } scan_ctl_t;

  typedef struct packed {
    logic              busy;
    logic              have;
    logic [IDX_W-1:0]  idx;
    logic [DIST_W-1:0] distance;
  } best_t;

endpackage

// File: rtl/vqcb_ram.sv
// ----------------------------------------------------------------------------
// vqcb_ram
// Simple dual-port synchronous RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module vqcb_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/vqcb_dist.sv
// ----------------------------------------------------------------------------
// vqcb_dist
// Distance datapath: per-row L1 sum of eight byte differences, accumulation
// over the rows of one entry, and tracking of the nearest compatible entry.
// ----------------------------------------------------------------------------
module vqcb_dist (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  vqcb_pkg::scan_ctl_t        issue,
  input  logic [vqcb_pkg::ROW_W-1:0] probe_row,
  input  logic [vqcb_pkg::ROW_W-1:0] entry_row,
  input  logic [vqcb_pkg::TAG_W-1:0] entry_tag,
  input  logic [vqcb_pkg::TAG_W-1:0] probe_tag,
  output vqcb_pkg::best_t            best
);
  import vqcb_pkg::*;

  scan_ctl_t             s1_r, s2_r;
  logic [ROW_W-1:0]      prow_r;
  logic [ROWSUM_W-1:0]   rowsum, rowsum_r;
  logic                  compat, compat_r;
  logic [7:0]            diff [BYTES_PER_BEAT];
  logic [DIST_W-1:0]     acc_r, total;
  logic                  have_r;
  logic [IDX_W-1:0]      best_idx_r;
  logic [DIST_W-1:0]     best_dist_r;

  // Byte differences and row sum, aligned with RAM read data
  always_comb begin
    rowsum = '0;
    for (int k = 0; k < BYTES_PER_BEAT; k++) begin
      diff[k] = (prow_r[8*k +: 8] > entry_row[8*k +: 8]) ?
                (prow_r[8*k +: 8] - entry_row[8*k +: 8]) :
                (entry_row[8*k +: 8] - prow_r[8*k +: 8]);
      rowsum  = rowsum + ROWSUM_W'(diff[k]);
    end
  end

  assign compat = (entry_tag == WILDCARD_TAG) || (probe_tag == WILDCARD_TAG) ||
                  (entry_tag == probe_tag);

  assign total = acc_r + DIST_W'(rowsum_r);

  // Advance the two pipeline stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r <= '0;
      s2_r <= '0;
    end else begin
      s1_r <= issue;
      s2_r <= s1_r;
    end
    prow_r   <= probe_row;
    rowsum_r <= rowsum;
    compat_r <= compat;
  end

  // Accumulate and keep the nearest entry; strict compare keeps lowest index
  always_ff @(posedge clk) begin
    if (!rst_n || start) begin
      acc_r       <= '0;
      have_r      <= 1'b0;
      best_idx_r  <= '0;
      best_dist_r <= NO_MATCH_DIST;
    end else if (s2_r.vld) begin
      acc_r <= s2_r.last ? '0 : total;
      if (s2_r.last && compat_r && (!have_r || total < best_dist_r)) begin
        have_r      <= 1'b1;
        best_idx_r  <= s2_r.idx;
        best_dist_r <= total;
      end
    end
  end

  assign best.busy     = s1_r.vld || s2_r.vld;
  assign best.have     = have_r;
  assign best.idx      = best_idx_r;
  assign best.distance = best_dist_r;

endmodule

// File: rtl/vq_codebook_add_or_lookup.sv
// ----------------------------------------------------------------------------
// vq_codebook_add_or_lookup
// Codebook of up to 256 64-byte vectors with nearest-entry L1 search.
// ----------------------------------------------------------------------------
// Probe beats are taken one per cycle while in_stall is low. After the last
// beat the block scans the stored entries, reading one 8-byte row of the
// vector memory per cycle, as the vector memory has a single read port.
// After the scan the distance pipeline drains and the result is decided; a
// hit or a fallback then reads the use count and writes it back incremented
// for an add command, and an append copies the probe into the vector memory
// row by row. With an empty table the scan is skipped. While a transaction
// is in progress, in_stall is high; a last beat is also held off while a
// result waits on the output.
// ----------------------------------------------------------------------------
module vq_codebook_add_or_lookup (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_command,
  input  logic [vqcb_pkg::TAG_W-1:0]     in_scale_tag,
  input  logic [vqcb_pkg::CHUNK_W-1:0]   in_vector_chunk,
  input  logic                           in_last_chunk,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_found,
  output logic [vqcb_pkg::IDX_W-1:0]     out_entry_index,
  output logic [vqcb_pkg::DIST_W-1:0]    out_best_distance,
  output logic                           out_was_added,
  output logic                           out_was_fallback,
  output logic [vqcb_pkg::CNT_W-1:0]     out_use_count,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [vqcb_pkg::ADDR_W-1:0]    paddr,
  input  logic [vqcb_pkg::DATA_W-1:0]    pwdata,
  output logic [vqcb_pkg::DATA_W-1:0]    prdata,
  output logic                           pready
);
  import vqcb_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_DRAIN, ST_DECIDE, ST_READ, ST_UPDATE, ST_COPY
  } state_t;

  state_t               state_r, state_nxt;
  logic [BEAT_W-1:0]    beat_r, beat_nxt;
  logic [ROW_W-1:0]     probe_r [BEATS];
  logic [ROW_W-1:0]     probe_nxt [BEATS];
  logic                 cmd_r, cmd_nxt;
  logic [TAG_W-1:0]     tag_r, tag_nxt;
  logic [DIST_W-1:0]    thr_r;
  logic [USED_W-1:0]    used_r, used_nxt;
  logic [IDX_W-1:0]     scan_idx_r, scan_idx_nxt;
  logic [BEAT_W-1:0]    scan_beat_r, scan_beat_nxt;
  logic [IDX_W-1:0]     tgt_r, tgt_nxt;
  logic                 bump_r, bump_nxt;
  logic                 fb_r, fb_nxt;
  logic                 ov_r, ov_nxt;
  logic                 of_r, of_nxt;
  logic [IDX_W-1:0]     oi_r, oi_nxt;
  logic [DIST_W-1:0]    od_r, od_nxt;
  logic                 oa_r, oa_nxt;
  logic                 ofb_r, ofb_nxt;
  logic [CNT_W-1:0]     oc_r, oc_nxt;

  logic                 in_acc, cfg_wr, start, hit, clear_probe;
  scan_ctl_t            issue;
  best_t                best;
  logic [ROW_W-1:0]     vec_rdata;
  logic [TAG_W-1:0]     tag_rdata;
  logic [CNT_W-1:0]     cnt_rdata, cnt_wdata;
  logic                 cnt_we;
  logic [IDX_W-1:0]     cnt_waddr;

  // Handshakes
  assign in_stall = (state_r != ST_IDLE) || (ov_r && in_last_chunk);
  assign in_acc   = in_valid && !in_stall;
  assign start    = in_acc && in_last_chunk;
  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && (paddr[2] == REG_THRESHOLD);
  assign prdata   = (paddr[2] == REG_THRESHOLD) ? DATA_W'(thr_r) : '0;

  // Threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= '0;
    end else if (cfg_wr) begin
      thr_r <= pwdata[DIST_W-1:0];
    end
  end

  // Scan issue: one row of one entry per cycle
  assign issue.vld  = (state_r == ST_SCAN);
  assign issue.last = (scan_beat_r == BEAT_W'(BEATS - 1));
  assign issue.idx  = scan_idx_r;

  assign hit = best.have && (best.distance <= thr_r);

  // Count memory write port
  always_comb begin
    cnt_we    = 1'b0;
    cnt_waddr = tgt_r;
    cnt_wdata = cnt_rdata + CNT_W'(1);
    if (state_r == ST_UPDATE) begin
      cnt_we = bump_r;
    end else if (state_r == ST_COPY && scan_beat_r == '0) begin
      cnt_we    = 1'b1;
      cnt_waddr = used_r[IDX_W-1:0];
      cnt_wdata = CNT_W'(1);
    end
  end

  // Next-state logic
  always_comb begin
    state_nxt     = state_r;
    beat_nxt      = beat_r;
    probe_nxt     = probe_r;
    cmd_nxt       = cmd_r;
    tag_nxt       = tag_r;
    used_nxt      = used_r;
    scan_idx_nxt  = scan_idx_r;
    scan_beat_nxt = scan_beat_r;
    tgt_nxt       = tgt_r;
    bump_nxt      = bump_r;
    fb_nxt        = fb_r;
    ov_nxt        = ov_r && out_stall;
    of_nxt        = of_r;
    oi_nxt        = oi_r;
    od_nxt        = od_r;
    oa_nxt        = oa_r;
    ofb_nxt       = ofb_r;
    oc_nxt        = oc_r;
    clear_probe   = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          probe_nxt[beat_r] = in_vector_chunk[ROW_W-1:0];
          if (in_last_chunk) begin
            cmd_nxt       = in_command;
            tag_nxt       = in_scale_tag;
            beat_nxt      = '0;
            scan_idx_nxt  = '0;
            scan_beat_nxt = '0;
            state_nxt     = (used_r == '0) ? ST_DRAIN : ST_SCAN;
          end else begin
            beat_nxt = (beat_r == BEAT_W'(BEATS - 1)) ? '0 : beat_r + BEAT_W'(1);
          end
        end
      end
      ST_SCAN: begin
        scan_beat_nxt = scan_beat_r + BEAT_W'(1);
        if (issue.last) begin
          if (USED_W'(scan_idx_r) == used_r - USED_W'(1)) begin
            state_nxt = ST_DRAIN;
          end else begin
            scan_idx_nxt = scan_idx_r + IDX_W'(1);
          end
        end
      end
      ST_DRAIN: begin
        if (!best.busy) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        fb_nxt = 1'b0;
        if (hit) begin
          tgt_nxt   = best.idx;
          bump_nxt  = cmd_r;
          state_nxt = ST_READ;
        end else if (cmd_r && !used_r[USED_W-1]) begin
          scan_beat_nxt = '0;
          state_nxt     = ST_COPY;
        end else if (cmd_r) begin
          tgt_nxt   = best.have ? best.idx : '0;
          bump_nxt  = 1'b1;
          fb_nxt    = 1'b1;
          state_nxt = ST_READ;
        end else begin
          // Lookup miss
          ov_nxt      = 1'b1;
          of_nxt      = 1'b0;
          oi_nxt      = '0;
          od_nxt      = best.distance;
          oa_nxt      = 1'b0;
          ofb_nxt     = 1'b0;
          oc_nxt      = '0;
          clear_probe = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      ST_READ: begin
        state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        ov_nxt      = 1'b1;
        of_nxt      = 1'b1;
        oi_nxt      = tgt_r;
        od_nxt      = best.distance;
        oa_nxt      = 1'b0;
        ofb_nxt     = fb_r;
        oc_nxt      = bump_r ? cnt_wdata : cnt_rdata;
        clear_probe = 1'b1;
        state_nxt   = ST_IDLE;
      end
      ST_COPY: begin
        scan_beat_nxt = scan_beat_r + BEAT_W'(1);
        if (scan_beat_r == BEAT_W'(BEATS - 1)) begin
          ov_nxt      = 1'b1;
          of_nxt      = 1'b1;
          oi_nxt      = used_r[IDX_W-1:0];
          od_nxt      = best.distance;
          oa_nxt      = 1'b1;
          ofb_nxt     = 1'b0;
          oc_nxt      = CNT_W'(1);
          used_nxt    = used_r + USED_W'(1);
          clear_probe = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    // Drop the probe after each completed transaction
    if (clear_probe) begin
      for (int b = 0; b < BEATS; b++) begin
        probe_nxt[b] = '0;
      end
    end
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      beat_r  <= '0;
      used_r  <= '0;
      ov_r    <= 1'b0;
      for (int b = 0; b < BEATS; b++) begin
        probe_r[b] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      beat_r  <= beat_nxt;
      used_r  <= used_nxt;
      ov_r    <= ov_nxt;
      probe_r <= probe_nxt;
    end
    cmd_r       <= cmd_nxt;
    tag_r       <= tag_nxt;
    scan_idx_r  <= scan_idx_nxt;
    scan_beat_r <= scan_beat_nxt;
    tgt_r       <= tgt_nxt;
    bump_r      <= bump_nxt;
    fb_r        <= fb_nxt;
    of_r        <= of_nxt;
    oi_r        <= oi_nxt;
    od_r        <= od_nxt;
    oa_r        <= oa_nxt;
    ofb_r       <= ofb_nxt;
    oc_r        <= oc_nxt;
  end

  assign out_valid         = ov_r;
  assign out_found         = of_r;
  assign out_entry_index   = oi_r;
  assign out_best_distance = od_r;
  assign out_was_added     = oa_r;
  assign out_was_fallback  = ofb_r;
  assign out_use_count     = oc_r;

  // Entry vector rows, addressed by entry and row
  vqcb_ram #(.DEPTH(ENTRIES * BEATS), .WIDTH(ROW_W)) u_vec_ram (
    .clk   (clk),
    .we    (state_r == ST_COPY),
    .waddr ({used_r[IDX_W-1:0], scan_beat_r}),
    .wdata (probe_r[scan_beat_r]),
    .raddr ({scan_idx_r, scan_beat_r}),
    .rdata (vec_rdata)
  );

  // Entry scale tags
  vqcb_ram #(.DEPTH(ENTRIES), .WIDTH(TAG_W)) u_tag_ram (
    .clk   (clk),
    .we    (state_r == ST_COPY && scan_beat_r == '0),
    .waddr (used_r[IDX_W-1:0]),
    .wdata (tag_r),
    .raddr (scan_idx_r),
    .rdata (tag_rdata)
  );

  // Entry use counts
  vqcb_ram #(.DEPTH(ENTRIES), .WIDTH(CNT_W)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (tgt_r),
    .rdata (cnt_rdata)
  );

  vqcb_dist u_dist (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .issue     (issue),
    .probe_row (probe_r[scan_beat_r]),
    .entry_row (vec_rdata),
    .entry_tag (tag_rdata),
    .probe_tag (tag_r),
    .best      (best)
  );

endmodule

// File: rtl/vqcb_checker.sv
// ----------------------------------------------------------------------------
// vqcb_checker
// Port-level checks of the codebook result channel, bound to the top level.
// ----------------------------------------------------------------------------
module vqcb_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic                        out_found,
  input logic [vqcb_pkg::IDX_W-1:0]  out_entry_index,
  input logic [vqcb_pkg::DIST_W-1:0] out_best_distance,
  input logic                        out_was_added,
  input logic                        out_was_fallback,
  input logic [vqcb_pkg::CNT_W-1:0]  out_use_count
);
  import vqcb_pkg::*;

  // Hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_entry_index) &&
                               $stable(out_use_count))
    else $error("stalled result changed");

  // Miss reports no entry
  a_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_entry_index == '0 && out_use_count == '0 &&
                                !out_was_added && !out_was_fallback)
    else $error("miss carries entry data");

  // Append starts a count of one
  a_add: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_was_added |-> out_found && !out_was_fallback &&
                                   out_use_count == CNT_W'(1))
    else $error("bad append result");

  // Fallback always returns an entry
  a_fb: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_was_fallback |-> out_found)
    else $error("fallback without entry");

  // Distance within range
  a_dist: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_best_distance <= NO_MATCH_DIST)
    else $error("distance out of range");

endmodule

bind vq_codebook_add_or_lookup vqcb_checker u_vqcb_checker (.*);
